@@ design/dtq_pkg.sv @@
// Shared types and constants of the deadline timer queue.
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

  // Fixed field widths of the command and result words.
  localparam int FUNC_W    = 2;
  localparam int TV_W      = 48;
  localparam int PAYLOAD_W = 32;
  localparam int HANDLE_W  = 4;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int ORDER_W   = 32;

  // A tick fires at most this many entries.
  localparam int MAX_FIRE   = 16;
  localparam int FIRE_CNT_W = $clog2(MAX_FIRE);

  // Function codes of an input word.
  localparam logic [FUNC_W-1:0] FUNC_ADD_REL = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD_ABS = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd3;

  // Kind codes of a result word.
  localparam logic [KIND_W-1:0] KIND_ADD       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_IDLE_TICK = 2'd3;

  // Status codes of a result word.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic add;
    logic cancel;
    logic tick;
    logic scan_start;
    logic scan_step;
    logic fire;
    logic fire_last;
    logic idle_tick;
  } dtq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              scan_done;
    logic              found;
    logic              multi;
  } dtq_status_t;

endpackage

`default_nettype wire

@@ design/dtq_ctrl.sv @@
// Controller state machine of the deadline timer queue.
`timescale 1ns / 1ps
`default_nettype none

module dtq_ctrl
  import dtq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire dtq_status_t status_i,
  output dtq_cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_FIRE
  } state_e;

  state_e                state_q;
  logic                  busy_q;
  logic [FIRE_CNT_W-1:0] n_q;

  assign busy_o = busy_q;

  // Commands decoded from the state and the datapath status.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.latch = start_i;
      end
      ST_DISPATCH: begin
        case (status_i.func)
          FUNC_ADD_REL, FUNC_ADD_ABS: cmd_o.add = 1'b1;
          FUNC_CANCEL: cmd_o.cancel = 1'b1;
          default: begin
            cmd_o.tick       = 1'b1;
            cmd_o.scan_start = 1'b1;
          end
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ST_FIRE: begin
        if (status_i.found) begin
          cmd_o.fire       = 1'b1;
          cmd_o.fire_last  = !status_i.multi || (n_q == FIRE_CNT_W'(MAX_FIRE - 1));
          cmd_o.scan_start = !cmd_o.fire_last;
        end else begin
          cmd_o.idle_tick = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  // State, busy flag and firing count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      n_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_DISPATCH;
            busy_q  <= 1'b1;
          end
        end
        ST_DISPATCH: begin
          if (status_i.func == FUNC_TICK) begin
            state_q <= ST_SCAN;
            n_q     <= '0;
          end else begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (status_i.scan_done) begin
            state_q <= ST_FIRE;
          end
        end
        ST_FIRE: begin
          if (cmd_o.fire && !cmd_o.fire_last) begin
            n_q     <= n_q + FIRE_CNT_W'(1);
            state_q <= ST_SCAN;
          end else begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  // At most one result word is produced per cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.add, cmd_o.cancel, cmd_o.fire, cmd_o.idle_tick}))
    else $error("dtq_ctrl: more than one result command");

  // A scan that finds nothing due can only be the first of a tick.
  a_empty_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIRE && !status_i.found) |-> (n_q == '0))
    else $error("dtq_ctrl: empty scan after a firing");

  // A word is only latched while the block is free.
  a_latch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |-> !busy_q)
    else $error("dtq_ctrl: latch while busy");

endmodule

`default_nettype wire

@@ design/dtq_datapath.sv @@
// Datapath of the deadline timer queue: entry store, clock, scan unit and result register.
`timescale 1ns / 1ps
`default_nettype none

module dtq_datapath
  import dtq_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int TIME_BITS = 48
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dtq_cmd_t             cmd_i,
  output dtq_status_t               status_o,
  input  wire logic [FUNC_W-1:0]    func_i,
  input  wire logic [TV_W-1:0]      time_value_i,
  input  wire logic                 cancelable_i,
  input  wire logic [PAYLOAD_W-1:0] payload_i,
  input  wire logic [HANDLE_W-1:0]  handle_i,
  output logic                      result_valid_o,
  output logic [KIND_W-1:0]         kind_o,
  output logic [STATUS_W-1:0]       status_out_o,
  output logic [HANDLE_W-1:0]       handle_out_o,
  output logic                      handle_valid_o,
  output logic [PAYLOAD_W-1:0]      payload_out_o,
  output logic [TV_W-1:0]           deadline_out_o,
  output logic                      last_o
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = ((TIME_BITS > TV_W) ? TIME_BITS : TV_W) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Latched input word.
  logic [FUNC_W-1:0]    func_q;
  logic [TV_W-1:0]      tv_q;
  logic                 canc_q;
  logic [PAYLOAD_W-1:0] pay_q;
  logic [HANDLE_W-1:0]  handle_q;

  // Entry store: flags in flip-flops, the wide fields in memories.
  logic [CAPACITY-1:0]  valid_q, valid_d;
  logic [CAPACITY-1:0]  cancel_ok_q;
  logic [TIME_BITS-1:0] mem_dl    [CAPACITY];
  logic [ORDER_W-1:0]   mem_order [CAPACITY];
  logic [PAYLOAD_W-1:0] mem_pay   [CAPACITY];

  logic [TIME_BITS-1:0] time_q, time_d;
  logic [ORDER_W-1:0]   ic_q;

  // Scan unit.
  logic [CNT_W-1:0]     idx_q;
  logic                 rd_en;
  logic                 cmp_v_q;
  logic [IDX_W-1:0]     cmp_idx_q;
  logic [TIME_BITS-1:0] rd_dl_q;
  logic [ORDER_W-1:0]   rd_order_q;
  logic [PAYLOAD_W-1:0] rd_pay_q;
  logic                 found_q, multi_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [TIME_BITS-1:0] best_dl_q;
  logic [ORDER_W-1:0]   best_age_q;
  logic [PAYLOAD_W-1:0] best_pay_q;
  logic [ORDER_W-1:0]   cand_age;
  logic                 cand_due, cand_better;

  // Add and cancel decisions.
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic [TIME_BITS-1:0] tv_t, rel_dl, add_dl;
  logic [SUM_W-1:0]     rel_sum;
  logic                 h_in_range, cancel_hit;
  logic [IDX_W-1:0]     h_idx;
  logic                 mem_we;

  logic                 result_valid_q;

  assign status_o.func      = func_q;
  assign status_o.scan_done = (idx_q == CNT_W'(CAPACITY)) && !cmp_v_q;
  assign status_o.found     = found_q;
  assign status_o.multi     = multi_q;

  // Input word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q   <= func_i;
      tv_q     <= time_value_i;
      canc_q   <= cancelable_i;
      pay_q    <= payload_i;
      handle_q <= handle_i;
    end
  end

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Deadline of an add: saturating relative sum or masked absolute value.
  // The sum is formed on the full delay so that a delay beyond the time range saturates.
  always_comb begin
    tv_t    = TIME_BITS'(tv_q);
    rel_sum = SUM_W'(time_q) + SUM_W'(tv_q);
    rel_dl  = (rel_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : rel_sum[TIME_BITS-1:0];
    add_dl  = (func_q == FUNC_ADD_REL) ? rel_dl : tv_t;
  end

  // Cancel lookup by handle.
  assign h_in_range = (32'(handle_q) < 32'(CAPACITY));
  assign h_idx      = IDX_W'(handle_q);
  assign cancel_hit = h_in_range && valid_q[h_idx] && cancel_ok_q[h_idx];

  assign mem_we = cmd_i.add && free_found;
  assign rd_en  = cmd_i.scan_step && (idx_q < CNT_W'(CAPACITY));

  // Next time: saturating increment on a tick.
  assign time_d = (time_q == TIME_MAX) ? time_q : time_q + TIME_BITS'(1);

  // Valid flags: set on add, cleared on a cancel hit or a firing.
  always_comb begin
    valid_d = valid_q;
    if (mem_we) begin
      valid_d[free_idx] = 1'b1;
    end
    if (cmd_i.cancel && cancel_hit) begin
      valid_d[h_idx] = 1'b0;
    end
    if (cmd_i.fire) begin
      valid_d[best_idx_q] = 1'b0;
    end
  end

  // Candidate of the compare stage.
  assign cand_age    = ic_q - rd_order_q;
  assign cand_due    = cmp_v_q && valid_q[cmp_idx_q] && (rd_dl_q <= time_q);
  assign cand_better = !found_q || (rd_dl_q < best_dl_q) ||
                       ((rd_dl_q == best_dl_q) && (cand_age > best_age_q));

  // Entry memories with a registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_dl[free_idx]    <= add_dl;
      mem_order[free_idx] <= ic_q;
      mem_pay[free_idx]   <= pay_q;
      cancel_ok_q[free_idx] <= canc_q;
    end
    if (rd_en) begin
      rd_dl_q    <= mem_dl[idx_q[IDX_W-1:0]];
      rd_order_q <= mem_order[idx_q[IDX_W-1:0]];
      rd_pay_q   <= mem_pay[idx_q[IDX_W-1:0]];
      cmp_idx_q  <= idx_q[IDX_W-1:0];
    end
  end

  // Control state of the store, the clock and the scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= '0;
      time_q         <= '0;
      ic_q           <= '0;
      idx_q          <= '0;
      cmp_v_q        <= 1'b0;
      found_q        <= 1'b0;
      multi_q        <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      valid_q        <= valid_d;
      result_valid_q <= cmd_i.add | cmd_i.cancel | cmd_i.fire | cmd_i.idle_tick;
      if (mem_we) begin
        ic_q <= ic_q + ORDER_W'(1);
      end
      if (cmd_i.tick) begin
        time_q <= time_d;
      end
      if (cmd_i.scan_start) begin
        idx_q   <= '0;
        cmp_v_q <= 1'b0;
        found_q <= 1'b0;
        multi_q <= 1'b0;
      end else begin
        cmp_v_q <= rd_en;
        if (rd_en) begin
          idx_q <= idx_q + CNT_W'(1);
        end
        if (cand_due) begin
          found_q <= 1'b1;
          if (found_q) begin
            multi_q <= 1'b1;
          end
        end
      end
    end
  end

  // Best due entry of the current scan.
  always_ff @(posedge clk_i) begin
    if (cand_due && cand_better && !cmd_i.scan_start) begin
      best_idx_q <= cmp_idx_q;
      best_dl_q  <= rd_dl_q;
      best_age_q <= cand_age;
      best_pay_q <= rd_pay_q;
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      kind_o         <= KIND_ADD;
      payload_out_o  <= '0;
      last_o         <= 1'b1;
      if (free_found) begin
        status_out_o   <= STAT_OK;
        handle_out_o   <= canc_q ? HANDLE_W'(free_idx) : '0;
        handle_valid_o <= canc_q;
        deadline_out_o <= TV_W'(add_dl);
      end else begin
        status_out_o   <= STAT_FULL;
        handle_out_o   <= '0;
        handle_valid_o <= 1'b0;
        deadline_out_o <= '0;
      end
    end else if (cmd_i.cancel) begin
      kind_o         <= KIND_CANCEL;
      status_out_o   <= cancel_hit ? STAT_OK : STAT_NOT_FOUND;
      handle_out_o   <= '0;
      handle_valid_o <= 1'b0;
      payload_out_o  <= '0;
      deadline_out_o <= '0;
      last_o         <= 1'b1;
    end else if (cmd_i.fire) begin
      kind_o         <= KIND_FIRED;
      status_out_o   <= STAT_OK;
      handle_out_o   <= HANDLE_W'(best_idx_q);
      handle_valid_o <= 1'b1;
      payload_out_o  <= best_pay_q;
      deadline_out_o <= TV_W'(best_dl_q);
      last_o         <= cmd_i.fire_last;
    end else if (cmd_i.idle_tick) begin
      kind_o         <= KIND_IDLE_TICK;
      status_out_o   <= STAT_OK;
      handle_out_o   <= '0;
      handle_valid_o <= 1'b0;
      payload_out_o  <= '0;
      deadline_out_o <= TV_W'(time_q);
      last_o         <= 1'b1;
    end
  end

  assign result_valid_o = result_valid_q;

  // A fired entry leaves the store.
  a_fire_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire |=> !valid_q[$past(best_idx_q)])
    else $error("dtq_datapath: fired entry still valid");

  // The chosen entry is always due.
  a_best_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire |-> (best_dl_q <= time_q))
    else $error("dtq_datapath: firing an entry that is not due");

  // Multiple due entries imply at least one found.
  a_multi_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    multi_q |-> found_q)
    else $error("dtq_datapath: multi flag without a find");

endmodule

`default_nettype wire

@@ design/deadline_timer_queue.sv @@
// Top level of the deadline timer queue.
`timescale 1ns / 1ps
`default_nettype none

// Store of up to CAPACITY timed entries, fired earliest deadline first.
// Command channel: a word is taken at a rising edge with start_i high and
// busy_o low. func_i selects a relative add, an absolute add, a cancel by
// handle or a one millisecond tick.
// Result channel: each result word is shown for exactly one cycle while
// result_valid_o is high; the receiver cannot stall it. last_o marks the
// final word caused by a command.
// An add or a cancel is latched at the accept edge, decided in the dispatch
// state and written to the result register; busy_o falls as the block returns
// to idle, so a new command is taken only once the previous one is done.
// A tick runs one scan round per fired entry (at most sixteen). In each round
// the entries are read one a cycle from the store memory and compared
// against the best due entry so far. A tick with nothing due takes one round.
// Reset empties the store and clears the time and the insertion count.
module deadline_timer_queue
  import dtq_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int TIME_BITS = 48
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [FUNC_W-1:0]    func_i,
  input  wire logic [TV_W-1:0]      time_value_i,
  input  wire logic                 cancelable_i,
  input  wire logic [PAYLOAD_W-1:0] payload_i,
  input  wire logic [HANDLE_W-1:0]  handle_i,
  output logic                      result_valid_o,
  output logic [KIND_W-1:0]         kind_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic [HANDLE_W-1:0]       handle_out_o,
  output logic                      handle_valid_o,
  output logic [PAYLOAD_W-1:0]      payload_out_o,
  output logic [TV_W-1:0]           deadline_out_o,
  output logic                      last_o
);

  dtq_cmd_t    cmd;
  dtq_status_t dp_status;

  // Controller.
  dtq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .status_i (dp_status),
    .cmd_o    (cmd)
  );

  // Datapath.
  dtq_datapath #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .func_i         (func_i),
    .time_value_i   (time_value_i),
    .cancelable_i   (cancelable_i),
    .payload_i      (payload_i),
    .handle_i       (handle_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .status_out_o   (status_o),
    .handle_out_o   (handle_out_o),
    .handle_valid_o (handle_valid_o),
    .payload_out_o  (payload_out_o),
    .deadline_out_o (deadline_out_o),
    .last_o         (last_o)
  );

  // A result word only follows an accepted command.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("deadline_timer_queue: result word without a command");

endmodule

`default_nettype wire
